// File: design/pfb_pkg.sv
// ----------------------------------------------------------------------------
// Packed framebuffer package
// Shared types and constants for the packed-pixel frame store access block.
// ----------------------------------------------------------------------------
package pfb_pkg;

	// Depth mode codes.
	localparam logic [2:0] DM_1BPP  = 3'd0;
	localparam logic [2:0] DM_3BPP  = 3'd1;
	localparam logic [2:0] DM_4BPP  = 3'd2;
	localparam logic [2:0] DM_8BPP  = 3'd3;
	localparam logic [2:0] DM_16BPP = 3'd4;
	localparam logic [2:0] DM_24BPP = 3'd5;
	localparam logic [2:0] DM_32BPP = 3'd6;
	localparam logic [2:0] DM_NONE  = 3'd7;

	// Status codes.
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_UNSUPP  = 2'd2;
	localparam logic [1:0] ST_BEYOND  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_DEPTH  = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [31:0] pixel_value;
	} pfb_in_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [1:0]  status;
	} pfb_out_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;    // capture the request and start address math
		logic mul;     // compute the linear pixel index product
		logic addr;    // form byte address and range check
		logic rd;      // issue a read of the current byte
		logic wr;      // write the merged byte (writes only), collect read bits and step on
		logic finish;  // present the result
	} pfb_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic reject;   // access is rejected, no store traffic
		logic last;     // current byte is the pixel's last byte
	} pfb_sts_t;

endpackage

// File: design/packed_framebuffer_pixel_access.sv
// Sequence: the accept in IDLE, then MUL, ADDR, a RD and a WR state for each byte touched
// (up to four bytes), then FIN. An access outside the image or at an unsupported depth
// goes from MUL to FIN, one past the store from RD to FIN. One access at a time, taken
// only in IDLE; the byte-wide store port sets the pace.
// Results appear for one cycle on done; the receiver cannot stall.
// Reset restores the registers to 1 bpp, 128 x 64; store contents are undefined.
// ----------------------------------------------------------------------------
// Packed framebuffer pixel access
// Reads or writes one pixel of a packed frame store at seven depths.
// ----------------------------------------------------------------------------
module packed_framebuffer_pixel_access #(
	parameter int STORE_BYTES = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pfb_pkg::pfb_in_t req,
	output logic             done,
	output pfb_pkg::pfb_out_t res,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import pfb_pkg::*;

	logic [2:0]  depth_mode_q;
	logic [15:0] image_width_q, image_height_q;
	pfb_cmd_t cmd;
	pfb_sts_t sts;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q   <= DM_1BPP;
			image_width_q  <= 16'd128;
			image_height_q <= 16'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEPTH:  depth_mode_q   <= cfg_data[2:0];
				REG_WIDTH:  image_width_q  <= cfg_data;
				REG_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pfb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	pfb_datapath #(.STORE_BYTES(STORE_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .depth_mode(depth_mode_q),
		.image_width(image_width_q), .image_height(image_height_q),
		.req(req), .cmd(cmd), .sts(sts), .res(res)
	);

endmodule

// File: design/pfb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One optional write and one read per cycle at the same address, registered read data.
// ----------------------------------------------------------------------------
module pfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Optional write and registered read at one address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: design/pfb_datapath.sv
// ----------------------------------------------------------------------------
// Packed framebuffer datapath
// Address math, range checks, byte read-modify-write and result assembly.
// ----------------------------------------------------------------------------
module pfb_datapath #(
	parameter int STORE_BYTES = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [2:0]      depth_mode,
	input  logic [15:0]     image_width,
	input  logic [15:0]     image_height,
	input  pfb_pkg::pfb_in_t  req,
	input  pfb_pkg::pfb_cmd_t cmd,
	output pfb_pkg::pfb_sts_t sts,
	output pfb_pkg::pfb_out_t res
);
	import pfb_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);

	pfb_in_t     req_q;
	logic [31:0] prod_q;      // row * pitch or row * width
	logic [35:0] base_q;      // first byte address
	logic [1:0]  cnt_q;       // byte within pixel
	logic [1:0]  nbytes_q;    // bytes touched minus one
	logic        reject_q;
	logic [1:0]  status_q;
	logic [31:0] rd_acc_q;
	logic [AW-1:0] ram_addr;
	logic [7:0]  ram_rdata;
	logic [7:0]  ram_wdata;

	// Pitch in units chosen by depth.
	logic [16:0] mul_b;
	always_comb begin
		unique case (depth_mode)
			DM_1BPP: mul_b = ({1'b0, image_width} + 17'd7) >> 3;
			DM_4BPP: mul_b = ({1'b0, image_width} + 17'd1) >> 1;
			default: mul_b = {1'b0, image_width};
		endcase
	end

	// Bytes per pixel minus one for byte-wide depths.
	logic [1:0] bpp_m1;
	always_comb begin
		unique case (depth_mode)
			DM_16BPP: bpp_m1 = 2'd1;
			DM_24BPP: bpp_m1 = 2'd2;
			DM_32BPP: bpp_m1 = 2'd3;
			default:  bpp_m1 = 2'd0;
		endcase
	end

	// Linear address from product.
	logic [35:0] lin, first_addr, last_addr, bitpos;
	always_comb begin
		lin = {4'd0, prod_q} + 36'(req_q.pos_x);
		bitpos = (lin << 1) + lin;
		unique case (depth_mode)
			DM_1BPP: begin
				first_addr = {4'd0, prod_q} + 36'(req_q.pos_x >> 3);
				last_addr  = first_addr;
			end
			DM_3BPP: begin
				first_addr = bitpos >> 3;
				last_addr  = (bitpos + 36'd2) >> 3;
			end
			DM_4BPP: begin
				first_addr = {4'd0, prod_q} + 36'(req_q.pos_x >> 1);
				last_addr  = first_addr;
			end
			default: begin
				// Scale by one to four bytes with shifts and one add.
				case (bpp_m1)
					2'd0:    first_addr = lin;
					2'd1:    first_addr = lin << 1;
					2'd2:    first_addr = bitpos;
					default: first_addr = lin << 2;
				endcase
				last_addr  = first_addr + 36'(bpp_m1);
			end
		endcase
	end

	// Current byte address: first byte plus byte count.
	logic [35:0] cur_addr;
	assign cur_addr = base_q + 36'(cnt_q);
	assign ram_addr = cur_addr[AW-1:0];

	// Merge of the current byte.
	logic [2:0] bit0;
	logic [7:0] mask, bits;
	always_comb begin
		bit0 = bitpos[2:0];
		mask = 8'h00;
		bits = 8'h00;
		unique case (depth_mode)
			DM_1BPP: begin
				mask = 8'h01 << req_q.pos_x[2:0];
				bits = req_q.pixel_value[0] ? mask : 8'h00;
			end
			DM_3BPP: begin
				// Bits of this byte from a 3-bit field shifted to bit0.
				logic [10:0] sh;
				sh = 11'(req_q.pixel_value[2:0]) << bit0;
				if (cnt_q == 2'd0) begin
					mask = 8'((11'h007 << bit0));
					bits = sh[7:0];
				end else begin
					mask = 8'((11'h007 << bit0) >> 8);
					bits = {5'd0, sh[10:8]};
				end
			end
			DM_4BPP: begin
				mask = req_q.pos_x[0] ? 8'h0F : 8'hF0;
				bits = req_q.pos_x[0] ? {4'd0, req_q.pixel_value[3:0]}
					: {req_q.pixel_value[3:0], 4'd0};
			end
			default: begin
				mask = 8'hFF;
				bits = req_q.pixel_value[8*cnt_q +: 8];
			end
		endcase
		ram_wdata = (ram_rdata & ~mask) | (bits & mask);
	end

	pfb_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
		.clk  (clk),
		.we   (cmd.wr & req_q.kind),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Extracted read bits of the current byte.
	logic [31:0] rd_part;
	always_comb begin
		logic [10:0] ex;
		ex = 11'h000;
		rd_part = 32'd0;
		unique case (depth_mode)
			DM_1BPP: rd_part = {31'd0, |(ram_rdata & mask)};
			DM_3BPP: begin
				if (cnt_q == 2'd0) begin
					ex = 11'(ram_rdata & mask) >> bit0;
				end else begin
					ex = {ram_rdata[2:0] & mask[2:0], 8'd0} >> bit0;
				end
				rd_part = {29'd0, ex[2:0]};
			end
			DM_4BPP: rd_part = {28'd0, req_q.pos_x[0] ? ram_rdata[3:0] : ram_rdata[7:4]};
			default: rd_part = 32'(ram_rdata) << (8 * cnt_q);
		endcase
	end

	// Sequenced datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q    <= '0;
			prod_q   <= '0;
			base_q   <= '0;
			nbytes_q <= '0;
			rd_acc_q <= '0;
			cnt_q    <= '0;
			reject_q <= 1'b0;
			status_q <= ST_DONE;
			res      <= '0;
		end else begin
			if (cmd.load) begin
				req_q    <= req;
				cnt_q    <= '0;
				rd_acc_q <= '0;
				reject_q <= 1'b0;
				status_q <= ST_DONE;
				if (req.pos_x >= image_width || req.pos_y >= image_height) begin
					reject_q <= 1'b1;
					status_q <= ST_OUTSIDE;
				end else if (depth_mode == DM_NONE) begin
					reject_q <= 1'b1;
					status_q <= ST_UNSUPP;
				end
			end
			if (cmd.mul) begin
				prod_q <= 32'(req_q.pos_y * mul_b);
			end
			if (cmd.addr) begin
				base_q   <= first_addr;
				nbytes_q <= 2'(last_addr - first_addr);
				if (last_addr >= 36'(STORE_BYTES)) begin
					reject_q <= 1'b1;
					status_q <= ST_BEYOND;
				end
			end
			if (cmd.wr) begin
				rd_acc_q <= rd_acc_q | rd_part;
				cnt_q    <= cnt_q + 2'd1;
			end
			if (cmd.finish) begin
				res.status     <= status_q;
				res.read_value <= (reject_q || req_q.kind) ? 32'd0 : rd_acc_q;
			end
		end
	end

	assign sts.reject = reject_q;
	assign sts.last   = (cnt_q == nbytes_q);

endmodule

// File: design/pfb_ctrl.sv
// ----------------------------------------------------------------------------
// Packed framebuffer controller
// Sequences address math, then a RD and a WR state for each byte's read-modify-write.
// ----------------------------------------------------------------------------
module pfb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pfb_pkg::pfb_sts_t sts,
	output pfb_pkg::pfb_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	import pfb_pkg::*;

	typedef enum logic [2:0] {IDLE, MUL, ADDR, RD, WR, FIN} state_t;
	state_t state_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == IDLE) && start;
		cmd.mul    = (state_q == MUL);
		cmd.addr   = (state_q == ADDR);
		cmd.rd     = (state_q == RD);
		cmd.wr     = (state_q == WR);
		cmd.finish = (state_q == FIN);
	end

	assign busy = (state_q != IDLE);

	// State register and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done    <= 1'b0;
		end else begin
			done <= (state_q == FIN);
			unique case (state_q)
				IDLE: if (start) state_q <= MUL;
				MUL:  state_q <= sts.reject ? FIN : ADDR;
				ADDR: state_q <= RD;
				RD:   state_q <= sts.reject ? FIN : WR;
				WR:   state_q <= sts.last ? FIN : RD;
				FIN:  state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// File: dv/tb_packed_framebuffer_pixel_access.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed framebuffer pixel access testbench
// Drives pixel reads and writes through several depth and image size settings,
// predicts every result with a behavioral frame store, and compares each done
// transfer against the oldest predicted result. Reads and sub-byte writes only
// touch bytes that were written before, so the store never yields unknowns.
// ----------------------------------------------------------------------------
module tb_packed_framebuffer_pixel_access;
	import pfb_pkg::*;

	localparam int STORE = 65536;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	pfb_in_t req;
	logic done;
	pfb_out_t res;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	packed_framebuffer_pixel_access #(.STORE_BYTES(STORE)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the frame store and of the registers.
	logic [7:0] pix_bytes [STORE];
	bit byte_known [STORE];
	logic [2:0] cur_depth;
	logic [15:0] cur_width;
	logic [15:0] cur_height;

	pfb_in_t pending_q[$];
	pfb_out_t pixel_result_q[$];
	int mismatches;

	// Clock.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Byte span touched by a pixel; returns 0 when the pixel is off the store.
	function automatic bit pixel_span(input logic [15:0] x, input logic [15:0] y,
			output longint first, output longint last);
		longint w;
		longint n;
		w = cur_width;
		case (cur_depth)
			DM_1BPP: begin
				first = longint'(y) * ((w + 7) >> 3) + (x >> 3);
				last = first;
			end
			DM_3BPP: begin
				first = (longint'(y) * w + x) * 3;
				last = (first + 2) >> 3;
				first = first >> 3;
			end
			DM_4BPP: begin
				first = longint'(y) * ((w + 1) >> 1) + (x >> 1);
				last = first;
			end
			default: begin
				n = (cur_depth == DM_8BPP) ? 1 : (cur_depth == DM_16BPP) ? 2 :
					(cur_depth == DM_24BPP) ? 3 : 4;
				first = (longint'(y) * w + x) * n;
				last = first + n - 1;
			end
		endcase
		return last < STORE;
	endfunction

	// True when the access would make the block read a byte never written.
	function automatic bit touches_unknown(input pfb_in_t it);
		longint first;
		longint last;
		if (it.pos_x >= cur_width || it.pos_y >= cur_height) return 0;
		if (cur_depth == DM_NONE) return 0;
		if (!pixel_span(it.pos_x, it.pos_y, first, last)) return 0;
		if (it.kind && cur_depth > DM_4BPP) return 0;
		for (longint a = first; a <= last; a++)
			if (!byte_known[a]) return 1;
		return 0;
	endfunction

	// Frame store prediction: applies the access and returns its result.
	function automatic pfb_out_t pixel_access(input pfb_in_t it);
		pfb_out_t r;
		longint first;
		longint last;
		longint p;
		int unsigned nb;
		r.read_value = '0;
		r.status = ST_DONE;
		if (it.pos_x >= cur_width || it.pos_y >= cur_height) begin
			r.status = ST_OUTSIDE;
			return r;
		end
		if (cur_depth == DM_NONE) begin
			r.status = ST_UNSUPP;
			return r;
		end
		if (!pixel_span(it.pos_x, it.pos_y, first, last)) begin
			r.status = ST_BEYOND;
			return r;
		end
		case (cur_depth)
			DM_1BPP: begin
				if (it.kind) pix_bytes[first][it.pos_x[2:0]] = it.pixel_value[0];
				else r.read_value = 32'(pix_bytes[first][it.pos_x[2:0]]);
			end
			DM_3BPP: begin
				p = (longint'(it.pos_y) * cur_width + it.pos_x) * 3;
				for (int i = 0; i < 3; i++) begin
					if (it.kind) pix_bytes[(p + i) >> 3][(p + i) & 7] = it.pixel_value[i];
					else r.read_value[i] = pix_bytes[(p + i) >> 3][(p + i) & 7];
				end
			end
			DM_4BPP: begin
				if (it.pos_x[0]) begin
					if (it.kind) pix_bytes[first][3:0] = it.pixel_value[3:0];
					else r.read_value = 32'(pix_bytes[first][3:0]);
				end else begin
					if (it.kind) pix_bytes[first][7:4] = it.pixel_value[3:0];
					else r.read_value = 32'(pix_bytes[first][7:4]);
				end
			end
			default: begin
				nb = int'(last - first) + 1;
				for (int i = 0; i < nb; i++) begin
					if (it.kind) begin
						pix_bytes[first + i] = it.pixel_value[8*i +: 8];
						byte_known[first + i] = 1;
					end else begin
						r.read_value[8*i +: 8] = pix_bytes[first + i];
					end
				end
			end
		endcase
		if (it.kind) r.read_value = '0;
		return r;
	endfunction

	// Queue one access with its predicted result.
	task automatic queue_access(input pfb_in_t it);
		if (touches_unknown(it)) it.pos_x = 16'hFFFF;
		pixel_result_q.push_back(pixel_access(it));
		pending_q.push_back(it);
	endtask

	// Random access: mostly inside the image, some anywhere.
	task automatic queue_random(input int n);
		pfb_in_t it;
		int tries;
		for (int k = 0; k < n; k++) begin
			tries = 0;
			do begin
				it.kind = 1'($urandom_range(0, 1));
				it.pixel_value = $urandom();
				if ($urandom_range(0, 9) < 8 && cur_width != 0 && cur_height != 0) begin
					it.pos_x = 16'($urandom_range(0, cur_width - 1));
					it.pos_y = 16'($urandom_range(0, cur_height - 1));
				end else begin
					it.pos_x = 16'($urandom());
					it.pos_y = 16'($urandom());
				end
				tries++;
			end while (touches_unknown(it) && tries < 8);
			queue_access(it);
		end
	endtask

	// Corners and value extremes, each write followed by a read back, then one outside access.
	task automatic queue_corners();
		pfb_in_t it;
		for (int c = 0; c < 2; c++) begin
			for (int v = 0; v < 2; v++) begin
				it.pos_x = c ? cur_width - 16'd1 : 16'd0;
				it.pos_y = c ? cur_height - 16'd1 : 16'd0;
				it.pixel_value = v ? 32'hFFFF_FFFF : 32'h0;
				it.kind = 1'b1;
				queue_access(it);
				it.kind = 1'b0;
				it.pixel_value = ~it.pixel_value;
				queue_access(it);
			end
		end
		it.pos_x = 16'hFFFF;
		it.pos_y = 16'hFFFF;
		queue_access(it);
	endtask

	// Wait for all transfers to finish, then let the block settle.
	task automatic drain();
		wait (pending_q.size() == 0 && !start && pixel_result_q.size() == 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_mode(input logic [2:0] d, input logic [15:0] w,
			input logic [15:0] h);
		drain();
		write_reg(REG_DEPTH, 16'(d));
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cur_depth = d;
		cur_width = w;
		cur_height = h;
	endtask

	// Sender: bursts of transfers with random gaps.
	int burst_left;
	int gap_left;
	bit accepted;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			accepted = start && !busy;
			if (accepted) void'(pending_q.pop_front());
			if (start && !accepted) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_q.size() > 0) begin
				start <= 1'b1;
				req <= pending_q[0];
				if (burst_left == 0) burst_left = $urandom_range(1, 30);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result checker.
	pfb_out_t want;
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pixel_result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: value %h status %0d", res.read_value,
						res.status);
			end else begin
				want = pixel_result_q.pop_front();
				if (res.read_value !== want.read_value || res.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected value %h status %0d, got value %h status %0d",
							want.read_value, want.status, res.read_value, res.status);
				end
			end
		end
	end

	// Stimulus and phase sequencing.
	pfb_in_t fill;
	initial begin
		mismatches = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEPTH;
		cfg_data = '0;
		cur_depth = DM_1BPP;
		cur_width = 16'd128;
		cur_height = 16'd64;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: only rejected accesses are safe before any fill.
		queue_corners();
		// Fill the first kilobyte with whole-pixel writes.
		set_mode(DM_32BPP, 16'd64, 16'd4);
		for (int i = 0; i < 256; i++) begin
			fill.kind = 1'b1;
			fill.pos_x = 16'(i % 64);
			fill.pos_y = 16'(i / 64);
			fill.pixel_value = $urandom();
			queue_access(fill);
		end
		queue_random(40);
		set_mode(DM_1BPP, 16'd128, 16'd64);   queue_corners(); queue_random(90);
		set_mode(DM_3BPP, 16'd100, 16'd27);   queue_corners(); queue_random(90);
		set_mode(DM_4BPP, 16'd63, 16'd32);    queue_corners(); queue_random(90);
		set_mode(DM_8BPP, 16'd1000, 16'd1);   queue_corners(); queue_random(70);
		set_mode(DM_16BPP, 16'd33, 16'd15);   queue_corners(); queue_random(70);
		set_mode(DM_24BPP, 16'd17, 16'd20);   queue_corners(); queue_random(70);
		set_mode(DM_NONE, 16'd16, 16'd16);    queue_random(20);
		set_mode(DM_8BPP, 16'd0, 16'd5);      queue_random(10);
		set_mode(DM_32BPP, 16'hFFFF, 16'hFFFF); queue_corners(); queue_random(60);
		set_mode(DM_1BPP, 16'hFFFF, 16'hFFFF);  queue_corners(); queue_random(60);
		set_mode(DM_3BPP, 16'd1, 16'hFFFF);     queue_corners(); queue_random(60);
		for (int ph = 0; ph < 4; ph++) begin
			set_mode(3'($urandom_range(0, 6)), 16'($urandom_range(1, 80)),
				16'($urandom_range(1, 40)));
			queue_random(60);
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pixel_result_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
design/pfb_pkg.sv
design/pfb_ram.sv
design/pfb_datapath.sv
design/pfb_ctrl.sv
design/packed_framebuffer_pixel_access.sv
dv/tb_packed_framebuffer_pixel_access.sv
